[src/ccpp_pkg.sv]
// Shared types and constants for the class file constant pool parser.
// Holds the parse phase encoding, result kinds, tag values and the payload size table.
// No dependencies.
`default_nettype none

package ccpp_pkg;

	typedef enum logic [4:0] {
		PH_HEADER  = 5'b00001,
		PH_TAG     = 5'b00010,
		PH_FIELDS  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_HEADER  = 2'd0;
	localparam kind_t KIND_ENTRY   = 2'd1;
	localparam kind_t KIND_PAYLOAD = 2'd2;
	localparam kind_t KIND_BAD_TAG = 2'd3;

	localparam logic [7:0] TAG_UTF8         = 8'd1;
	localparam logic [7:0] TAG_INTEGER      = 8'd3;
	localparam logic [7:0] TAG_FLOAT        = 8'd4;
	localparam logic [7:0] TAG_LONG         = 8'd5;
	localparam logic [7:0] TAG_DOUBLE       = 8'd6;
	localparam logic [7:0] TAG_CLASS        = 8'd7;
	localparam logic [7:0] TAG_STRING       = 8'd8;
	localparam logic [7:0] TAG_FIELDREF     = 8'd9;
	localparam logic [7:0] TAG_METHODREF    = 8'd10;
	localparam logic [7:0] TAG_IMETHODREF   = 8'd11;
	localparam logic [7:0] TAG_NAMEANDTYPE  = 8'd12;
	localparam logic [7:0] TAG_METHODHANDLE = 8'd15;
	localparam logic [7:0] TAG_METHODTYPE   = 8'd16;
	localparam logic [7:0] TAG_INVOKEDYN    = 8'd18;

	localparam logic [3:0] HDR_GATHER_BYTES = 4'd8;
	localparam logic [3:0] HDR_BYTES        = 4'd10;

	function automatic logic [3:0] payload_size(input logic [7:0] tag);
		logic [3:0] size;
		case (tag)
			TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHODTYPE: size = 4'd2;
			TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF,
			TAG_NAMEANDTYPE, TAG_INVOKEDYN: size = 4'd4;
			TAG_LONG, TAG_DOUBLE: size = 4'd8;
			TAG_METHODHANDLE: size = 4'd3;
			default: size = 4'd0;
		endcase
		return size;
	endfunction

endpackage

`default_nettype wire

[src/class_constant_pool_parser_unit.sv]
// Top level of the class file constant pool parser: input register, parse logic, result register.
// Depends on ccpp_pkg for the phase encoding, result kinds, tags and payload sizes.
//
//   channel  | handshake                  | payload
//   input    | data_valid, data_stall     | data_byte, file_start
//   result   | result_valid, result_stall | result_kind .. pool_done
//
// One byte is taken per cycle unless stalled; its result is loaded from the input register.
// The parse state and the result register are updated together, at the same clock edge.
// Reset puts the parser in the header phase with all counters at zero.
// A stalled result holds the input register, which then stalls the input channel.
`default_nettype none

module class_constant_pool_parser_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         data_valid,
	output logic              data_stall,
	input  wire logic [7:0]   data_byte,
	input  wire logic         file_start,
	output logic              result_valid,
	input  wire logic         result_stall,
	output ccpp_pkg::kind_t   result_kind,
	output logic [15:0]       slot_number,
	output logic [7:0]        entry_tag,
	output logic [15:0]       first_ref,
	output logic [15:0]       second_ref,
	output logic [7:0]        handle_kind,
	output logic [63:0]       wide_value,
	output logic [15:0]       text_length,
	output logic [7:0]        payload_byte,
	output logic              pool_done
);
	import ccpp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	phase_t      phase_q;
	logic [3:0]  bc_q;
	logic [7:0]  tag_q;
	logic [63:0] gather_q;
	logic [15:0] slot_q;
	logic [15:0] pool_size_q;
	logic [15:0] text_rem_q;
	logic [15:0] hold_q;

	logic        res_valid_q;
	kind_t       kind_q;
	logic [15:0] slot_out_q;
	logic [7:0]  tag_out_q;
	logic [15:0] first_q;
	logic [15:0] second_q;
	logic [7:0]  handle_q;
	logic [63:0] wide_q;
	logic [15:0] text_len_q;
	logic [7:0]  payload_q;
	logic        done_q;

	logic        adv;
	logic        res_free;

	phase_t      ph;
	logic [3:0]  bc;
	logic [7:0]  tag;
	logic [63:0] g;
	logic [15:0] slot;
	logic [15:0] ps;
	logic [15:0] tr;
	logic [15:0] hold;

	phase_t      phase_n;
	logic [3:0]  bc_n;
	logic [7:0]  tag_n;
	logic [63:0] g_n;
	logic [15:0] slot_n;
	logic [15:0] ps_n;
	logic [15:0] tr_n;
	logic [15:0] hold_n;

	logic [3:0]  bc_inc;
	logic [63:0] g_shift;
	logic [16:0] next1;
	logic [16:0] next2;
	logic        done1;
	logic        done2;
	logic [15:0] tr_dec;

	logic        emit_c;
	kind_t       kind_c;
	logic [15:0] slot_c;
	logic [7:0]  tag_c;
	logic [15:0] first_c;
	logic [15:0] second_c;
	logic [7:0]  handle_c;
	logic [63:0] wide_c;
	logic [15:0] text_len_c;
	logic [7:0]  payload_c;
	logic        done_c;

	assign res_free   = !res_valid_q || !result_stall;
	assign adv        = valid_s1 && res_free;
	assign data_stall = valid_s1 && !res_free;

	always_comb begin
		ph   = start_s1 ? PH_HEADER : phase_q;
		bc   = start_s1 ? '0 : bc_q;
		tag  = start_s1 ? '0 : tag_q;
		g    = start_s1 ? '0 : gather_q;
		slot = start_s1 ? '0 : slot_q;
		ps   = start_s1 ? '0 : pool_size_q;
		tr   = start_s1 ? '0 : text_rem_q;
		hold = start_s1 ? '0 : hold_q;

		bc_inc  = bc + 4'd1;
		g_shift = {g[55:0], byte_s1};
		next1   = {1'b0, slot} + 17'd1;
		next2   = {1'b0, slot} + 17'd2;
		done1   = next1 >= {1'b0, ps};
		done2   = next2 >= {1'b0, ps};
		tr_dec  = tr - 16'd1;

		phase_n = ph;
		bc_n    = bc;
		tag_n   = tag;
		g_n     = g;
		slot_n  = slot;
		ps_n    = ps;
		tr_n    = tr;
		hold_n  = hold;

		emit_c     = 1'b0;
		kind_c     = KIND_HEADER;
		slot_c     = '0;
		tag_c      = '0;
		first_c    = '0;
		second_c   = '0;
		handle_c   = '0;
		wide_c     = '0;
		text_len_c = '0;
		payload_c  = '0;
		done_c     = 1'b0;

		case (ph)
			PH_HEADER: begin
				if (bc < HDR_GATHER_BYTES) begin
					g_n = g_shift;
				end else begin
					ps_n = {ps[7:0], byte_s1};
				end
				bc_n = bc_inc;
				if (bc_inc >= HDR_BYTES) begin
					emit_c   = 1'b1;
					kind_c   = KIND_HEADER;
					slot_c   = ps_n;
					first_c  = g[31:16];
					second_c = g[15:0];
					wide_c   = {32'd0, g[63:32]};
					slot_n   = 16'd1;
					bc_n     = '0;
					done_c   = ps_n <= 16'd1;
					phase_n  = done_c ? PH_DONE : PH_TAG;
				end
			end
			PH_TAG: begin
				tag_n = byte_s1;
				if (payload_size(byte_s1) == 4'd0) begin
					emit_c  = 1'b1;
					kind_c  = KIND_BAD_TAG;
					slot_c  = slot;
					tag_c   = byte_s1;
					done_c  = done1;
					slot_n  = next1[15:0];
					bc_n    = '0;
					phase_n = done1 ? PH_DONE : PH_TAG;
				end else begin
					phase_n = PH_FIELDS;
					bc_n    = '0;
					g_n     = '0;
				end
			end
			PH_FIELDS: begin
				g_n  = g_shift;
				bc_n = bc_inc;
				if (bc_inc >= payload_size(tag)) begin
					emit_c  = 1'b1;
					kind_c  = KIND_ENTRY;
					slot_c  = slot;
					tag_c   = tag;
					done_c  = done1;
					slot_n  = next1[15:0];
					bc_n    = '0;
					phase_n = done1 ? PH_DONE : PH_TAG;
					case (tag)
						TAG_UTF8: begin
							hold_n     = g_shift[15:0];
							tr_n       = g_shift[15:0];
							text_len_c = g_shift[15:0];
							if (g_shift[15:0] != 16'd0) begin
								done_c  = 1'b0;
								slot_n  = slot;
								phase_n = PH_PAYLOAD;
							end
						end
						TAG_CLASS, TAG_STRING, TAG_METHODTYPE: begin
							first_c = g_shift[15:0];
						end
						TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMEANDTYPE,
						TAG_INVOKEDYN: begin
							first_c  = g_shift[31:16];
							second_c = g_shift[15:0];
						end
						TAG_INTEGER, TAG_FLOAT: begin
							wide_c = {32'd0, g_shift[31:0]};
						end
						TAG_LONG, TAG_DOUBLE: begin
							wide_c  = g_shift;
							done_c  = done2;
							slot_n  = next2[15:0];
							phase_n = done2 ? PH_DONE : PH_TAG;
						end
						TAG_METHODHANDLE: begin
							handle_c = g_shift[23:16];
							first_c  = g_shift[15:0];
						end
						default: begin
							first_c = '0;
						end
					endcase
				end
			end
			PH_PAYLOAD: begin
				emit_c     = 1'b1;
				kind_c     = KIND_PAYLOAD;
				slot_c     = slot;
				tag_c      = tag;
				text_len_c = hold;
				payload_c  = byte_s1;
				tr_n       = tr_dec;
				if (tr_dec == 16'd0) begin
					done_c  = done1;
					slot_n  = next1[15:0];
					bc_n    = '0;
					phase_n = done1 ? PH_DONE : PH_TAG;
				end
			end
			default: begin
				emit_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			bc_q        <= '0;
			tag_q       <= '0;
			gather_q    <= '0;
			slot_q      <= '0;
			pool_size_q <= '0;
			text_rem_q  <= '0;
			hold_q      <= '0;
		end else if (adv) begin
			phase_q     <= phase_n;
			bc_q        <= bc_n;
			tag_q       <= tag_n;
			gather_q    <= g_n;
			slot_q      <= slot_n;
			pool_size_q <= ps_n;
			text_rem_q  <= tr_n;
			hold_q      <= hold_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1 && emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_c) begin
			kind_q     <= kind_c;
			slot_out_q <= slot_c;
			tag_out_q  <= tag_c;
			first_q    <= first_c;
			second_q   <= second_c;
			handle_q   <= handle_c;
			wide_q     <= wide_c;
			text_len_q <= text_len_c;
			payload_q  <= payload_c;
			done_q     <= done_c;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = kind_q;
	assign slot_number  = slot_out_q;
	assign entry_tag    = tag_out_q;
	assign first_ref    = first_q;
	assign second_ref   = second_q;
	assign handle_kind  = handle_q;
	assign wide_value   = wide_q;
	assign text_length  = text_len_q;
	assign payload_byte = payload_q;
	assign pool_done    = done_q;

	a_stall_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && result_stall |-> data_stall)
		else $error("input not stalled while the result register is blocked");

	a_done_ends_pool: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit_c && done_c |=> phase_q == PH_DONE)
		else $error("pool end did not move the parser to the done phase");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> text_rem_q != 16'd0)
		else $error("payload phase with no bytes left");

	a_no_result_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !start_s1 && phase_q == PH_DONE |-> !emit_c)
		else $error("result produced after the pool ended");

endmodule

`default_nettype wire
